// File: design/aie_pkg.sv
`timescale 1ns / 1ps

package aie_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int MAX_SAMPLES = 4096;
  localparam int ADDR_W      = 12;
  localparam int CNT_W       = 13;
  localparam int NUM_LAGS    = 64;
  localparam int LAG_W       = 6;
  localparam int LAGS_W      = 7;
  localparam int SUM_W       = 44;
  localparam int DEV_W       = 33;
  localparam int PROD_W      = 66;
  localparam int ACC_W       = 78;
  localparam int DIV_W       = 80;
  localparam int TRAP_W      = 72;
  localparam int STEP_W      = 16;
  localparam int APROD_W     = TRAP_W + STEP_W;
  localparam int AHALF_W     = TRAP_W / 2;
  localparam int AMUL_W      = AHALF_W + STEP_W;
  localparam int RES_W       = 64;
  localparam int SPREAD_W    = 63;
  localparam int OUT_DATA_W  = 200;

  // Configuration register indexes
  localparam logic CFG_STEP_SIZE = 1'b0;
  localparam logic CFG_LAGS      = 1'b1;

  // Saturate a sign and magnitude to a signed 64-bit value
  function automatic logic [RES_W-1:0] sat_s64(input logic neg, input logic [DIV_W-1:0] mag);
    logic [RES_W-1:0] r;
    if (neg) begin
      if (mag > {{(DIV_W-RES_W){1'b0}}, 1'b1, {(RES_W-1){1'b0}}}) r = {1'b1, {(RES_W-1){1'b0}}};
      else r = RES_W'(0) - mag[RES_W-1:0];
    end else begin
      if (mag > {{(DIV_W-RES_W+1){1'b0}}, {(RES_W-1){1'b1}}}) r = {1'b0, {(RES_W-1){1'b1}}};
      else r = mag[RES_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: design/autocorrelation_integral_engine.sv
`timescale 1ns / 1ps

// Autocorrelation engine with trapezoid integral.
// Input stream: one Q16.16 sample per transfer on tdata, tlast marks the last
// sample of a series. Samples load at one per cycle into a 4096-entry store;
// samples past that are discarded and flagged in every result of the run.
// After the last sample the block stops accepting and sweeps the lags:
// first the mean (one 80-step division), then for each lag t below N the
// (N - t) pair products through the single pair multiply pipeline, a
// pipeline drain and an 80-step division by the pair count; lags at or
// above N give an empty zero result. The final result also computes the
// integral, multiplied in two halves. The divider is bit-serial and serves
// both the mean and the per-lag divisions.
// Output stream: one transfer per lag, lag 0 upward; tlast marks the final
// result, which also carries the variance and the integral.
// The output register holds a result while the receiver stalls; the sweep
// waits for it before loading the next one.
// Reset clears the series count, sum and drop flag, sets the timestep to 2.0
// and the lag count to 64. Configuration writes are taken at any cycle.
module autocorrelation_integral_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_addr_i,
  input  logic [aie_pkg::STEP_W-1:0]        cfg_wdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [aie_pkg::SAMPLE_W-1:0]      s_axis_tdata_i,  // sample[31:0]
  input  logic                              s_axis_tlast_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // lag[5:0], correlation[69:6], empty_lag[70], spread[133:71], area[197:134],
  // dropped[198], zero[199]
  output logic [aie_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  output logic                              m_axis_tlast_o
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_MDIV_GO  = 4'd1;
  localparam logic [3:0] ST_MDIV     = 4'd2;
  localparam logic [3:0] ST_LAG      = 4'd3;
  localparam logic [3:0] ST_PAIR     = 4'd4;
  localparam logic [3:0] ST_DRAIN    = 4'd5;
  localparam logic [3:0] ST_CDIV_GO  = 4'd6;
  localparam logic [3:0] ST_CDIV     = 4'd7;
  localparam logic [3:0] ST_POST     = 4'd8;
  localparam logic [3:0] ST_EMIT     = 4'd9;
  localparam logic [3:0] ST_AREA_MUL = 4'd10;
  localparam logic [3:0] ST_AREA_SAT = 4'd11;
  localparam logic [3:0] ST_EMIT_FIN = 4'd12;
  localparam logic [3:0] ST_AREA_HI  = 4'd13;

  logic [3:0]                          state_q;
  logic [aie_pkg::STEP_W-1:0]          step_q;
  logic [aie_pkg::LAGS_W-1:0]          lags_q;
  logic [aie_pkg::LAGS_W-1:0]          nlag_q;
  logic [aie_pkg::CNT_W-1:0]           count_q;
  logic signed [aie_pkg::SUM_W-1:0]    sum_q;
  logic                                ovf_q;
  logic signed [aie_pkg::SAMPLE_W-1:0] mean_q;
  logic [aie_pkg::LAG_W-1:0]           t_q;
  logic [aie_pkg::ADDR_W-1:0]          i_q;
  logic signed [aie_pkg::ACC_W-1:0]    acc_q;
  logic [aie_pkg::RES_W-1:0]           corr_q;
  logic                                empty_q;
  logic [aie_pkg::SPREAD_W-1:0]        spread_q;
  logic signed [aie_pkg::TRAP_W-1:0]   trap_q;
  logic [aie_pkg::APROD_W-1:0]         aprod_q;
  logic                                aneg_q;
  logic [aie_pkg::RES_W-1:0]           area_q;
  logic                                out_v_q;
  logic [aie_pkg::OUT_DATA_W-1:0]      out_data_q;
  logic                                out_last_q;

  // Pair pipeline
  logic                                p1_v_q, p2_v_q, p3_v_q;
  logic [aie_pkg::SAMPLE_W-1:0]        rd_a_q, rd_b_q;
  logic signed [aie_pkg::DEV_W-1:0]    dev_a_q, dev_b_q;
  logic signed [aie_pkg::PROD_W-1:0]   prod_q;

  logic [aie_pkg::SAMPLE_W-1:0]        sample_store [aie_pkg::MAX_SAMPLES];

  logic                                in_xfer;
  logic                                out_free;
  logic                                store_ok;
  logic                                div_start;
  logic [aie_pkg::DIV_W-1:0]           div_dividend;
  logic [aie_pkg::CNT_W-1:0]           div_divisor;
  logic                                div_done;
  logic [aie_pkg::DIV_W-1:0]           div_quo;
  logic                                sum_neg;
  logic [aie_pkg::SUM_W-1:0]           sum_mag;
  logic                                acc_neg;
  logic [aie_pkg::ACC_W-1:0]           acc_mag;
  logic                                trap_neg;
  logic [aie_pkg::TRAP_W-1:0]          trap_mag;
  logic [aie_pkg::CNT_W-1:0]           pairs_m1;
  logic [aie_pkg::ADDR_W-1:0]          addr_b;
  logic [aie_pkg::LAGS_W-1:0]          lags_clamp;
  logic                                is_first, is_last;
  logic signed [aie_pkg::TRAP_W-1:0]   corr_ext;
  logic [aie_pkg::APROD_W-10:0]        area_mag;
  logic [aie_pkg::AHALF_W-1:0]         amul_op;
  logic [aie_pkg::AMUL_W-1:0]          amul;

  assign in_xfer   = s_axis_tvalid_i && (state_q == ST_IDLE);
  assign out_free  = !out_v_q || m_axis_tready_i;
  assign store_ok  = count_q < aie_pkg::CNT_W'(aie_pkg::MAX_SAMPLES);

  assign sum_neg   = sum_q[aie_pkg::SUM_W-1];
  assign sum_mag   = sum_neg ? aie_pkg::SUM_W'(-sum_q) : aie_pkg::SUM_W'(sum_q);
  assign acc_neg   = acc_q[aie_pkg::ACC_W-1];
  assign acc_mag   = acc_neg ? aie_pkg::ACC_W'(-acc_q) : aie_pkg::ACC_W'(acc_q);
  assign trap_neg  = trap_q[aie_pkg::TRAP_W-1];
  assign trap_mag  = trap_neg ? aie_pkg::TRAP_W'(-trap_q) : aie_pkg::TRAP_W'(trap_q);
  assign pairs_m1  = count_q - {{(aie_pkg::CNT_W-aie_pkg::LAG_W){1'b0}}, t_q} - 1'b1;
  assign addr_b    = i_q + {{(aie_pkg::ADDR_W-aie_pkg::LAG_W){1'b0}}, t_q};
  assign is_first  = (t_q == '0);
  assign is_last   = ({1'b0, t_q} == nlag_q - 1'b1);
  assign corr_ext  = {{(aie_pkg::TRAP_W-aie_pkg::RES_W){corr_q[aie_pkg::RES_W-1]}}, corr_q};
  assign area_mag  = aprod_q[aie_pkg::APROD_W-1:9];

  // Area multiplier: low half of the magnitude first, then the high half
  assign amul_op   = (state_q == ST_AREA_MUL) ? trap_mag[aie_pkg::AHALF_W-1:0]
                                              : trap_mag[aie_pkg::TRAP_W-1:aie_pkg::AHALF_W];
  assign amul      = amul_op * step_q;

  // Clamp the lag count into 1..NUM_LAGS
  always_comb begin
    if (lags_q == '0) lags_clamp = aie_pkg::LAGS_W'(1);
    else if (lags_q > aie_pkg::LAGS_W'(aie_pkg::NUM_LAGS)) lags_clamp = aie_pkg::LAGS_W'(aie_pkg::NUM_LAGS);
    else lags_clamp = lags_q;
  end

  // Share the divider between the mean and the per-lag means
  assign div_start    = (state_q == ST_MDIV_GO) || (state_q == ST_CDIV_GO);
  assign div_dividend = (state_q == ST_MDIV_GO) ? aie_pkg::DIV_W'(sum_mag) : aie_pkg::DIV_W'(acc_mag);
  assign div_divisor  = (state_q == ST_MDIV_GO) ? count_q : pairs_m1 + 1'b1;

  aie_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= aie_pkg::STEP_W'(512);
      lags_q <= aie_pkg::LAGS_W'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        aie_pkg::CFG_STEP_SIZE: step_q <= cfg_wdata_i;
        aie_pkg::CFG_LAGS:      lags_q <= cfg_wdata_i[aie_pkg::LAGS_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (in_xfer && store_ok) sample_store[count_q[aie_pkg::ADDR_W-1:0]] <= s_axis_tdata_i;
    rd_a_q <= sample_store[i_q];
    rd_b_q <= sample_store[addr_b];
  end

  // Deviation and product stages
  always_ff @(posedge clk_i) begin
    dev_a_q <= {rd_a_q[aie_pkg::SAMPLE_W-1], rd_a_q} - {mean_q[aie_pkg::SAMPLE_W-1], mean_q};
    dev_b_q <= {rd_b_q[aie_pkg::SAMPLE_W-1], rd_b_q} - {mean_q[aie_pkg::SAMPLE_W-1], mean_q};
    prod_q  <= dev_a_q * dev_b_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
    end else begin
      p1_v_q <= (state_q == ST_PAIR);
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      sum_q      <= '0;
      ovf_q      <= 1'b0;
      nlag_q     <= '0;
      mean_q     <= '0;
      t_q        <= '0;
      i_q        <= '0;
      acc_q      <= '0;
      corr_q     <= '0;
      empty_q    <= 1'b0;
      spread_q   <= '0;
      trap_q     <= '0;
      aprod_q    <= '0;
      aneg_q     <= 1'b0;
      area_q     <= '0;
      out_v_q    <= 1'b0;
      out_data_q <= '0;
      out_last_q <= 1'b0;
    end else begin
      // Drop the output once taken, unless a new result loads this cycle
      if (out_v_q && m_axis_tready_i && (state_q != ST_EMIT) && (state_q != ST_EMIT_FIN)) begin
        out_v_q <= 1'b0;
      end
      if (p3_v_q) acc_q <= acc_q + aie_pkg::ACC_W'(prod_q);

      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            if (store_ok) begin
              count_q <= count_q + 1'b1;
              sum_q   <= sum_q + aie_pkg::SUM_W'($signed(s_axis_tdata_i));
            end else begin
              ovf_q <= 1'b1;
            end
            if (s_axis_tlast_i) begin
              nlag_q  <= lags_clamp;
              t_q     <= '0;
              trap_q  <= '0;
              state_q <= ST_MDIV_GO;
            end
          end
        end
        ST_MDIV_GO: state_q <= ST_MDIV;
        ST_MDIV: begin
          if (div_done) begin
            mean_q  <= sum_neg ? aie_pkg::SAMPLE_W'(-div_quo[aie_pkg::SAMPLE_W-1:0])
                               : div_quo[aie_pkg::SAMPLE_W-1:0];
            state_q <= ST_LAG;
          end
        end
        ST_LAG: begin
          // Lags with no pairs give zero and skip the sweep
          if ({{(aie_pkg::CNT_W-aie_pkg::LAG_W){1'b0}}, t_q} >= count_q) begin
            corr_q  <= '0;
            empty_q <= 1'b1;
            state_q <= ST_POST;
          end else begin
            i_q     <= '0;
            acc_q   <= '0;
            empty_q <= 1'b0;
            state_q <= ST_PAIR;
          end
        end
        ST_PAIR: begin
          i_q <= i_q + 1'b1;
          if ({1'b0, i_q} == pairs_m1) state_q <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (!p1_v_q && !p2_v_q && !p3_v_q) state_q <= ST_CDIV_GO;
        end
        ST_CDIV_GO: state_q <= ST_CDIV;
        ST_CDIV: begin
          if (div_done) begin
            corr_q  <= aie_pkg::sat_s64(acc_neg, div_quo);
            state_q <= ST_POST;
          end
        end
        ST_POST: begin
          // Fold this lag into the trapezoid sum
          if (is_first && is_last) trap_q <= trap_q;
          else if (is_first || is_last) trap_q <= trap_q + corr_ext;
          else trap_q <= trap_q + (corr_ext <<< 1);
          if (is_first) spread_q <= corr_q[aie_pkg::SPREAD_W-1:0];
          state_q <= is_last ? ST_AREA_MUL : ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_v_q    <= 1'b1;
            out_last_q <= 1'b0;
            out_data_q <= {1'b0, ovf_q, aie_pkg::RES_W'(0), aie_pkg::SPREAD_W'(0),
                           empty_q, corr_q, t_q};
            t_q        <= t_q + 1'b1;
            state_q    <= ST_LAG;
          end
        end
        ST_AREA_MUL: begin
          aprod_q <= aie_pkg::APROD_W'(amul);
          aneg_q  <= trap_neg;
          state_q <= ST_AREA_HI;
        end
        ST_AREA_HI: begin
          aprod_q <= aprod_q + {amul, aie_pkg::AHALF_W'(0)};
          state_q <= ST_AREA_SAT;
        end
        ST_AREA_SAT: begin
          area_q  <= aie_pkg::sat_s64(aneg_q, aie_pkg::DIV_W'(area_mag));
          state_q <= ST_EMIT_FIN;
        end
        ST_EMIT_FIN: begin
          if (out_free) begin
            out_v_q    <= 1'b1;
            out_last_q <= 1'b1;
            out_data_q <= {1'b0, ovf_q, area_q, spread_q, empty_q, corr_q, t_q};
            count_q    <= '0;
            sum_q      <= '0;
            ovf_q      <= 1'b0;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// File: design/aie_div.sv
`timescale 1ns / 1ps

module aie_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [aie_pkg::DIV_W-1:0]  dividend_i,
  input  logic [aie_pkg::CNT_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [aie_pkg::DIV_W-1:0]  quotient_o
);

  logic [aie_pkg::DIV_W-1:0] quo_q, quo_d;
  logic [aie_pkg::CNT_W-1:0] rem_q, rem_d;
  logic [aie_pkg::CNT_W-1:0] dsr_q;
  logic [6:0]                cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [aie_pkg::CNT_W:0]   shifted;
  logic [aie_pkg::CNT_W:0]   diff;

  // One restoring step per cycle, MSB first
  always_comb begin
    shifted = {rem_q, quo_q[aie_pkg::DIV_W-1]};
    diff    = shifted - {1'b0, dsr_q};
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (busy_q) begin
      if (!diff[aie_pkg::CNT_W]) begin
        rem_d = diff[aie_pkg::CNT_W-1:0];
        quo_d = {quo_q[aie_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[aie_pkg::CNT_W-1:0];
        quo_d = {quo_q[aie_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'(aie_pkg::DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Load operands on start
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
